// ===== hdl/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

  localparam int TPU_W = 11;
  localparam int TMO_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_WACK  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 1'd1;

  localparam logic [TPU_W-1:0] TPU_RESET = 11'd32;
  localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } req_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_item_t;

  typedef struct packed {
    logic [TPU_W-1:0] ticks_per_us;
    logic [TMO_W-1:0] ack_timeout;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/i2cbm_req_if.sv =====
`default_nettype none

interface i2cbm_req_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, action, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, action, tx_byte, send_ack, sda_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2cbm_res_if.sv =====
`default_nettype none

interface i2cbm_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_oe;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte, ack_error,
                  input ready);
  modport sink   (input valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte, ack_error,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/i2c_bit_level_master.sv =====
// Bit-level I2C master sequencer.
// Each request on the req channel is one bus tick: it may carry a command
// (start, stop, write byte, wait for acknowledge, read byte then ACK/NACK)
// and always carries the sampled SDA level. Every request yields exactly one
// response on the res channel: the SCL/SDA pin controls, busy, done, the last
// received byte and the acknowledge error flag after that tick.
// A request is registered on acceptance and processed by the sequencer into
// the response register once the output is free (res not stalled). While res
// is not stalled, one request is accepted every cycle; the combinational
// sequencer step is the limiting path.
// cfg_we/cfg_index/cfg_data write ticks_per_us (index 0) and ack_timeout
// (index 1); write them only while no requests are in flight.
// Reset empties both registers, idles the sequencer with SCL and SDA driven
// high, and sets ticks_per_us to 32 and ack_timeout to 250.
// If res is stalled the response holds and one further request is buffered;
// req.ready then drops until the response is taken.
`default_nettype none

module i2c_bit_level_master
  import i2cbm_pkg::*;
#(
  parameter int DELAY_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  i2cbm_req_if.sink                 req,
  i2cbm_res_if.source               res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TPU_W-1:0]     cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  req_item_t s1_item;
  logic      res_valid;
  res_item_t res_item;
  res_item_t step_res;
  logic      out_free;
  logic      step;

  assign out_free  = !res_valid || res.ready;
  assign step      = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  i2cbm_core #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (s1_item),
    .cfg   (cfg),
    .result(step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us <= TPU_RESET;
      cfg.ack_timeout  <= TMO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_US: cfg.ticks_per_us <= cfg_data;
        CFG_ACK_TIMEOUT:  cfg.ack_timeout  <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      s1_item.cmd_valid <= req.cmd_valid;
      s1_item.action    <= req.action;
      s1_item.tx_byte   <= req.tx_byte;
      s1_item.send_ack  <= req.send_ack;
      s1_item.sda_in    <= req.sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
    if (step) begin
      res_item <= step_res;
    end
  end

  assign res.valid     = res_valid;
  assign res.scl       = res_item.scl;
  assign res.sda_out   = res_item.sda_out;
  assign res.sda_oe    = res_item.sda_oe;
  assign res.busy_res  = res_item.busy_res;
  assign res.done_res  = res_item.done_res;
  assign res.rx_byte   = res_item.rx_byte;
  assign res.ack_error = res_item.ack_error;

endmodule

`default_nettype wire

// ===== hdl/i2cbm_core.sv =====
`default_nettype none

module i2cbm_core
  import i2cbm_pkg::*;
#(
  parameter int DELAY_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire req_item_t item,
  input  wire cfg_t      cfg,
  output res_item_t      result
);

  localparam int TW = (DELAY_WIDTH + 1 > TPU_W) ? DELAY_WIDTH + 1 : TPU_W;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3, PH_WA1, PH_WA2, PH_POLL,
    PH_WR1, PH_WR2, PH_WR3, PH_RD1, PH_RD2, PH_AK1, PH_AK2
  } phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             current_action, current_action_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic [4:0]             us_count, us_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [7:0]             ack_wait_count, ack_wait_count_next;
  logic                   ack_choice, ack_choice_next;
  logic                   scl_reg, scl_reg_next;
  logic                   sda_reg, sda_reg_next;
  logic                   sda_dir, sda_dir_next;
  logic [7:0]             rx_reg, rx_reg_next;
  logic                   err_flag, err_flag_next;
  logic                   done_now;

  logic [TW-1:0] tpu, cap, tick_next;
  logic          do_expire, do_enter;
  phase_t        enter_ph;

  always_comb begin
    cap = TW'(1) << DELAY_WIDTH;
    tpu = TW'(cfg.ticks_per_us);
    if (tpu == '0) tpu = TW'(1);
    if (tpu > cap) tpu = cap;
    tick_next = TW'(delay_count) + TW'(1);
  end

  always_comb begin
    phase_next          = phase;
    current_action_next = current_action;
    bit_count_next      = bit_count;
    delay_count_next    = delay_count;
    us_count_next       = us_count;
    shift_reg_next      = shift_reg;
    ack_wait_count_next = ack_wait_count;
    ack_choice_next     = ack_choice;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    sda_dir_next        = sda_dir;
    rx_reg_next         = rx_reg;
    err_flag_next       = err_flag;
    done_now            = 1'b0;
    do_expire           = 1'b0;
    do_enter            = 1'b0;
    enter_ph            = PH_IDLE;

    if (phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        current_action_next = item.action;
        bit_count_next      = '0;
        case (item.action)
          ACT_START: begin
            do_enter = 1'b1;
            enter_ph = PH_ST1;
          end
          ACT_STOP: begin
            do_enter = 1'b1;
            enter_ph = PH_SP1;
          end
          ACT_WRITE: begin
            sda_dir_next   = 1'b1;
            scl_reg_next   = 1'b0;
            shift_reg_next = item.tx_byte;
            do_enter       = 1'b1;
            enter_ph       = PH_WR1;
          end
          ACT_WACK: begin
            do_enter = 1'b1;
            enter_ph = PH_WA1;
          end
          ACT_READ: begin
            sda_dir_next    = 1'b0;
            shift_reg_next  = '0;
            ack_choice_next = item.send_ack;
            do_enter        = 1'b1;
            enter_ph        = PH_RD1;
          end
          default: current_action_next = '0;
        endcase
      end
    end else if (phase == PH_POLL) begin
      if (!item.sda_in) begin
        scl_reg_next  = 1'b0;
        err_flag_next = 1'b0;
        phase_next    = PH_IDLE;
        done_now      = 1'b1;
      end else if (ack_wait_count >= cfg.ack_timeout) begin
        err_flag_next = 1'b1;
        do_enter      = 1'b1;
        enter_ph      = PH_SP1;
      end else begin
        ack_wait_count_next = ack_wait_count + 8'd1;
      end
    end else if (us_count == '0) begin
      do_expire = 1'b1;
    end else if (tick_next >= tpu) begin
      delay_count_next = '0;
      us_count_next    = us_count - 5'd1;
      if (us_count_next == '0) do_expire = 1'b1;
    end else begin
      delay_count_next = tick_next[DELAY_WIDTH-1:0];
    end

    if (do_expire) begin
      do_enter = 1'b1;
      case (phase)
        PH_ST1: enter_ph = PH_ST2;
        PH_ST2: enter_ph = PH_ST3;
        PH_SP1: enter_ph = PH_SP2;
        PH_SP2: enter_ph = PH_SP3;
        PH_WA1: enter_ph = PH_WA2;
        PH_WA2: enter_ph = PH_POLL;
        PH_WR1: enter_ph = PH_WR2;
        PH_WR2: enter_ph = PH_WR3;
        PH_WR3: begin
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next >= 4'd8) begin
            do_enter   = 1'b0;
            phase_next = PH_IDLE;
            done_now   = 1'b1;
          end else begin
            enter_ph = PH_WR1;
          end
        end
        PH_RD1: enter_ph = PH_RD2;
        PH_RD2: begin
          bit_count_next = bit_count + 4'd1;
          enter_ph = (bit_count_next >= 4'd8) ? PH_AK1 : PH_RD1;
        end
        PH_AK1: enter_ph = PH_AK2;
        PH_AK2: begin
          do_enter     = 1'b0;
          scl_reg_next = 1'b0;
          rx_reg_next  = shift_reg;
          phase_next   = PH_IDLE;
          done_now     = 1'b1;
        end
        default: begin
          do_enter   = 1'b0;
          phase_next = PH_IDLE;
          done_now   = 1'b1;
        end
      endcase
    end

    if (do_enter) begin
      phase_next = enter_ph;
      case (enter_ph)
        PH_ST1: begin
          sda_dir_next = 1'b1;
          sda_reg_next = 1'b1;
          scl_reg_next = 1'b1;
          us_count_next = 5'd4;
          delay_count_next = '0;
        end
        PH_ST2: begin
          sda_reg_next = 1'b0;
          us_count_next = 5'd4;
          delay_count_next = '0;
        end
        PH_ST3: begin
          scl_reg_next = 1'b0;
          us_count_next = 5'd4;
          delay_count_next = '0;
        end
        PH_SP1: begin
          sda_dir_next = 1'b1;
          scl_reg_next = 1'b0;
          sda_reg_next = 1'b0;
          us_count_next = 5'd4;
          delay_count_next = '0;
        end
        PH_SP2: begin
          scl_reg_next = 1'b1;
          us_count_next = 5'd1;
          delay_count_next = '0;
        end
        PH_SP3: begin
          sda_reg_next = 1'b1;
          us_count_next = 5'd4;
          delay_count_next = '0;
        end
        PH_WA1: begin
          sda_dir_next = 1'b0;
          sda_reg_next = 1'b1;
          us_count_next = 5'd1;
          delay_count_next = '0;
        end
        PH_WA2: begin
          scl_reg_next = 1'b1;
          us_count_next = 5'd1;
          delay_count_next = '0;
        end
        PH_POLL: ack_wait_count_next = '0;
        PH_WR1: begin
          sda_reg_next   = shift_reg_next[7];
          shift_reg_next = {shift_reg_next[6:0], 1'b0};
          us_count_next = 5'd5;
          delay_count_next = '0;
        end
        PH_WR2: begin
          scl_reg_next = 1'b1;
          us_count_next = 5'd5;
          delay_count_next = '0;
        end
        PH_WR3, PH_RD1: begin
          scl_reg_next = 1'b0;
          us_count_next = 5'd5;
          delay_count_next = '0;
        end
        PH_RD2: begin
          scl_reg_next   = 1'b1;
          shift_reg_next = {shift_reg_next[6:0], item.sda_in};
          us_count_next = 5'd5;
          delay_count_next = '0;
        end
        PH_AK1: begin
          scl_reg_next = 1'b0;
          sda_dir_next = 1'b1;
          sda_reg_next = !ack_choice_next;
          us_count_next = ack_choice_next ? 5'd20 : 5'd5;
          delay_count_next = '0;
        end
        PH_AK2: begin
          scl_reg_next = 1'b1;
          us_count_next = ack_choice_next ? 5'd2 : 5'd5;
          delay_count_next = '0;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    result.scl       = scl_reg_next;
    result.sda_out   = sda_reg_next;
    result.sda_oe    = sda_dir_next;
    result.busy_res  = (phase_next != PH_IDLE);
    result.done_res  = done_now;
    result.rx_byte   = rx_reg_next;
    result.ack_error = err_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      current_action <= '0;
      bit_count      <= '0;
      delay_count    <= '0;
      us_count       <= '0;
      shift_reg      <= '0;
      ack_wait_count <= '0;
      ack_choice     <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      sda_dir        <= 1'b1;
      rx_reg         <= '0;
      err_flag       <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      current_action <= current_action_next;
      bit_count      <= bit_count_next;
      delay_count    <= delay_count_next;
      us_count       <= us_count_next;
      shift_reg      <= shift_reg_next;
      ack_wait_count <= ack_wait_count_next;
      ack_choice     <= ack_choice_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      sda_dir        <= sda_dir_next;
      rx_reg         <= rx_reg_next;
      err_flag       <= err_flag_next;
    end
  end

endmodule

`default_nettype wire
